// ===== src/lwf_pkg.sv =====
// lwf_pkg: shared types, constants and the angle-factor table
// for the lidar wall-follow pid block; no dependencies
package lwf_pkg;

  typedef struct packed {
    logic [15:0] range_mm;
    logic [9:0]  sample_index;
    logic        last_of_scan;
    logic [19:0] elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        speed_cmd;
    logic signed [15:0] steer_cmd;
  } out_item_t;

  typedef struct packed {
    logic [15:0] wall_distance;
    logic [14:0] steer_limit;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [15:0] stop_distance;
    logic [15:0] safe_distance;
    logic [15:0] speed_max;
  } cfg_t;

  // one finished scan handed from front to back
  typedef struct packed {
    logic [15:0] front_min;
    logic [15:0] left_min;
    logic [15:0] right_min;
    logic [19:0] elapsed_us;
  } job_t;

  localparam logic [2:0] REG_WALL_DIST  = 3'd0;
  localparam logic [2:0] REG_STEER_LIM  = 3'd1;
  localparam logic [2:0] REG_GAIN_P     = 3'd2;
  localparam logic [2:0] REG_GAIN_I     = 3'd3;
  localparam logic [2:0] REG_GAIN_D     = 3'd4;
  localparam logic [2:0] REG_STOP_DIST  = 3'd5;
  localparam logic [2:0] REG_SAFE_DIST  = 3'd6;
  localparam logic [2:0] REG_SPEED_MAX  = 3'd7;

  localparam logic [9:0]  FRONT_LO  = 10'd520;
  localparam logic [9:0]  FRONT_HI  = 10'd600;
  localparam logic [9:0]  LEFT_LO   = 10'd420;
  localparam logic [9:0]  LEFT_HI   = 10'd480;
  localparam logic [9:0]  RIGHT_LO  = 10'd600;
  localparam logic [9:0]  RIGHT_HI  = 10'd660;
  localparam logic [15:0] RANGE_MAX = 16'hFFFF;
  localparam logic [15:0] MIN_SPEED = 16'd3277;
  localparam logic [15:0] TOP_SPEED = 16'd32768;
  localparam logic [16:0] ONE_Q16   = 17'd65536;

  localparam int DIV_NUM_W = 58;
  localparam int DIV_DEN_W = 30;

  // reciprocals for the constant divisions, exact floor over the operand range
  // integral step: (e*dt*2^11 + 976562) / 1953125, via ceil(2^68 / 1953125)
  localparam logic [47:0] RCP_1E9  = 48'd151115727451829;
  localparam logic [47:0] RND_1E9  = 48'd976562;
  // p term: (gain_p*e*8 + 62) / 125, via ceil(2^42 / 125)
  localparam logic [47:0] RCP_1000 = 48'd35184372089;
  localparam logic [47:0] RND_1000 = 48'd62;

  // 1 - x^3.9 in q1.16 at steps of 1/32
  function automatic logic [16:0] angle_tab(input logic [5:0] i);
    logic [16:0] v;
    case (i)
      6'd0: v = 17'd65536;   6'd1: v = 17'd65536;
      6'd2: v = 17'd65535;   6'd3: v = 17'd65530;
      6'd4: v = 17'd65516;   6'd5: v = 17'd65489;
      6'd6: v = 17'd65440;   6'd7: v = 17'd65361;
      6'd8: v = 17'd65242;   6'd9: v = 17'd65070;
      6'd10: v = 17'd64834;  6'd11: v = 17'd64518;
      6'd12: v = 17'd64106;  6'd13: v = 17'd63583;
      6'd14: v = 17'd62928;  6'd15: v = 17'd62123;
      6'd16: v = 17'd61146;  6'd17: v = 17'd59975;
      6'd18: v = 17'd58586;  6'd19: v = 17'd56955;
      6'd20: v = 17'd55055;  6'd21: v = 17'd52858;
      6'd22: v = 17'd50336;  6'd23: v = 17'd47459;
      6'd24: v = 17'd44195;  6'd25: v = 17'd40512;
      6'd26: v = 17'd36376;  6'd27: v = 17'd31752;
      6'd28: v = 17'd26604;  6'd29: v = 17'd20894;
      6'd30: v = 17'd14583;  6'd31: v = 17'd7632;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/lwf_front.sv =====
// lwf_front: sector minimum tracking and a two-entry scan queue
// depends on lwf_pkg
module lwf_front import lwf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     job_valid,
  input  logic     job_ready,
  output job_t     job_data
);

  logic [15:0] front_min_r, left_min_r, right_min_r;
  logic [15:0] front_fold, left_fold, right_fold;
  job_t        q_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        in_fire, push, pop;
  logic        in_front, in_left, in_right;

  assign in_ready  = (cnt_r != 2'd2);
  assign in_fire   = in_valid & in_ready;
  assign push      = in_fire & in_data.last_of_scan;
  assign pop       = job_valid & job_ready;
  assign job_valid = (cnt_r != 2'd0);
  assign job_data  = q_r[rd_ptr_r];

  assign in_front = (in_data.sample_index >= FRONT_LO) && (in_data.sample_index < FRONT_HI);
  assign in_left  = (in_data.sample_index >= LEFT_LO) && (in_data.sample_index < LEFT_HI);
  assign in_right = (in_data.sample_index >= RIGHT_LO) && (in_data.sample_index < RIGHT_HI);

  always_comb begin
    front_fold = (in_front && in_data.range_mm < front_min_r) ? in_data.range_mm : front_min_r;
    left_fold  = (in_left && in_data.range_mm < left_min_r) ? in_data.range_mm : left_min_r;
    right_fold = (in_right && in_data.range_mm < right_min_r) ? in_data.range_mm : right_min_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_min_r <= RANGE_MAX;
      left_min_r  <= RANGE_MAX;
      right_min_r <= RANGE_MAX;
      wr_ptr_r    <= 1'b0;
      rd_ptr_r    <= 1'b0;
      cnt_r       <= 2'd0;
    end else begin
      if (in_fire) begin
        if (in_data.last_of_scan) begin
          front_min_r <= RANGE_MAX;
          left_min_r  <= RANGE_MAX;
          right_min_r <= RANGE_MAX;
        end else begin
          front_min_r <= front_fold;
          left_min_r  <= left_fold;
          right_min_r <= right_fold;
        end
      end
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{front_min: front_fold, left_min: left_fold,
                        right_min: right_fold, elapsed_us: in_data.elapsed_us};
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("scan queue over-filled");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0) else $error("pop from empty scan queue");
  a_min_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (front_min_r == RANGE_MAX && left_min_r == RANGE_MAX))
    else $error("sector minima not cleared after last sample");

endmodule

// ===== src/lwf_div.sv =====
// lwf_div: unsigned restoring divider, one quotient bit per cycle
// depends on lwf_pkg
module lwf_div import lwf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  localparam logic [5:0] LAST_STEP = 6'(DIV_NUM_W - 1);

  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r, rem_r;
  logic [DIV_DEN_W:0]   rem_sh, rem_sub;
  logic [5:0]           cnt_r;
  logic                 busy_r, done_r;
  logic                 ge;

  assign rem_sh  = {rem_r, num_r[DIV_NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign done    = done_r;
  assign quo     = num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      num_r <= {num_r[DIV_NUM_W-2:0], ge};
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider started while busy");
  a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == LAST_STEP) |=> done_r) else $error("divider missed done");

endmodule

// ===== src/lwf_back.sv =====
// lwf_back: per-scan pid step, speed law and output register
// depends on lwf_pkg and lwf_div
module lwf_back import lwf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_MUL1   = 13'b0000000000010,
    S_MUL2   = 13'b0000000000100,
    S_DIVI   = 13'b0000000001000,
    S_MULI   = 13'b0000000010000,
    S_DIVP   = 13'b0000000100000,
    S_DIVD   = 13'b0000001000000,
    S_SUM    = 13'b0000010000000,
    S_DIVF   = 13'b0000100000000,
    S_DIVA   = 13'b0001000000000,
    S_INTERP = 13'b0010000000000,
    S_SPEED  = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } back_state_t;

  back_state_t state_r;
  logic        wait_r;

  logic signed [16:0] e_r, last_err_r;
  logic signed [21:0] integ_r;
  logic [15:0]        front_r;
  logic [19:0]        dt_r;
  logic [35:0]        edt_r;
  logic [31:0]        pg_r;
  logic [32:0]        pd1_r;
  logic [48:0]        pd2_r;
  logic [36:0]        gi_r;
  logic signed [52:0] p_term_r, i_term_r, d_term_r;
  logic               diff_neg_r;
  logic signed [15:0] steer_r;
  logic [14:0]        mag_r;
  logic [16:0]        df_r, af_r, ratio_r;
  logic [15:0]        speed_r;
  logic               out_valid_r;
  out_item_t          out_data_r;
  logic [2:0]         rcp_cnt_r;
  logic [95:0]        rcp_acc_r;

  logic [15:0]          e_mag;
  logic signed [17:0]   diff;
  logic [16:0]          dmag;
  logic [20:0]          integ_mag;
  logic signed [29:0]   integ_ext, q_ext, integ_sum;
  logic signed [21:0]   integ_clamp;
  logic [37:0]          i_rnd;
  logic [52:0]          q53;
  logic signed [52:0]   steer_sum, lim;
  logic signed [15:0]   steer_clamp;
  logic [5:0]           tab_idx;
  logic [16:0]          tab_a, tab_b, drop;
  logic [27:0]          drop_prod;
  logic [16:0]          f_min;
  logic [15:0]          top;
  logic [32:0]          spd_prod;
  logic signed [16:0]   e_new;
  logic [47:0]          rcp_n, rcp_m;
  logic [23:0]          rcp_pa, rcp_pb;
  logic [47:0]          rcp_pp;
  logic [95:0]          rcp_acc_nxt;

  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;

  lwf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign job_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    e_new = (job_data.left_min < job_data.right_min)
          ? $signed({1'b0, cfg.wall_distance}) - $signed({1'b0, job_data.left_min})
          : $signed({1'b0, job_data.right_min}) - $signed({1'b0, cfg.wall_distance});
    e_mag     = e_r[16] ? 16'(-e_r) : 16'(e_r);
    diff      = {e_r[16], e_r} - {last_err_r[16], last_err_r};
    dmag      = diff[17] ? 17'(-diff) : 17'(diff);
    integ_mag = integ_r[21] ? 21'(-integ_r) : 21'(integ_r);
    integ_ext = {{8{integ_r[21]}}, integ_r};
    q_ext     = $signed({3'd0, rcp_acc_r[94:68]});
    integ_sum = e_r[16] ? integ_ext - q_ext : integ_ext + q_ext;
    if (integ_sum > 30'sd1048576) integ_clamp = 22'sd1048576;
    else if (integ_sum < -30'sd1048576) integ_clamp = -22'sd1048576;
    else integ_clamp = integ_sum[21:0];
    i_rnd     = 38'(gi_r) + 38'd8192;
    q53       = div_quo[52:0];
    steer_sum = p_term_r + i_term_r + d_term_r;
    lim       = $signed({38'd0, cfg.steer_limit});
    if (steer_sum > lim) steer_clamp = 16'(lim);
    else if (steer_sum < -lim) steer_clamp = 16'(-lim);
    else steer_clamp = steer_sum[15:0];
    tab_idx   = ratio_r[16:11];
    tab_a     = angle_tab(tab_idx);
    tab_b     = angle_tab(tab_idx + 6'd1);
    drop      = tab_a - tab_b;
    drop_prod = 28'(drop) * 28'(ratio_r[10:0]);
    f_min     = (df_r < af_r) ? df_r : af_r;
    top       = (cfg.speed_max > TOP_SPEED) ? TOP_SPEED : cfg.speed_max;
    spd_prod  = 33'(top - MIN_SPEED) * 33'(f_min) + 33'd32768;
  end

  // constant divisions by reciprocal multiply, four 24x24 partial products
  always_comb begin
    rcp_n = '0;
    rcp_m = '0;
    case (state_r)
      S_DIVI: begin
        rcp_n = 48'({edt_r, 11'd0}) + RND_1E9;
        rcp_m = RCP_1E9;
      end
      S_DIVP: begin
        rcp_n = 48'({pg_r, 3'd0}) + RND_1000;
        rcp_m = RCP_1000;
      end
      default: ;
    endcase
    rcp_pa = rcp_cnt_r[1] ? rcp_n[47:24] : rcp_n[23:0];
    rcp_pb = rcp_cnt_r[0] ? rcp_m[47:24] : rcp_m[23:0];
    rcp_pp = {24'd0, rcp_pa} * {24'd0, rcp_pb};
    case (rcp_cnt_r)
      3'd0:       rcp_acc_nxt = 96'(rcp_pp);
      3'd1, 3'd2: rcp_acc_nxt = rcp_acc_r + (96'(rcp_pp) << 24);
      default:    rcp_acc_nxt = rcp_acc_r + (96'(rcp_pp) << 48);
    endcase
  end

  // divider operands by state
  always_comb begin
    div_num   = '0;
    div_den   = '0;
    div_start = 1'b0;
    case (state_r)
      S_DIVD: begin
        div_num   = DIV_NUM_W'(pd2_r) + DIV_NUM_W'(dt_r >> 1);
        div_den   = DIV_DEN_W'(dt_r);
        div_start = !wait_r && (dt_r != 20'd0);
      end
      S_DIVF: begin
        div_num   = DIV_NUM_W'({16'(front_r - cfg.stop_distance), 16'd0});
        div_den   = DIV_DEN_W'(16'(cfg.safe_distance - cfg.stop_distance));
        div_start = !wait_r && (cfg.safe_distance > cfg.stop_distance)
                    && (front_r > cfg.stop_distance);
      end
      S_DIVA: begin
        div_num   = DIV_NUM_W'({mag_r, 16'd0});
        div_den   = DIV_DEN_W'(cfg.steer_limit);
        div_start = !wait_r && (cfg.steer_limit != 15'd0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      integ_r     <= '0;
      last_err_r  <= '0;
      out_valid_r <= 1'b0;
      rcp_cnt_r   <= 3'd0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;
      if (div_start) wait_r <= 1'b1;
      if (div_done) wait_r <= 1'b0;
      if ((state_r == S_DIVI || state_r == S_DIVP) && rcp_cnt_r != 3'd4)
        rcp_cnt_r <= rcp_cnt_r + 3'd1;
      else
        rcp_cnt_r <= 3'd0;
      case (state_r)
        S_IDLE: if (job_valid) state_r <= S_MUL1;
        S_MUL1: begin
          last_err_r <= e_r;
          state_r    <= S_MUL2;
        end
        S_MUL2: state_r <= S_DIVI;
        S_DIVI: if (rcp_cnt_r == 3'd4) begin
          integ_r <= integ_clamp;
          state_r <= S_MULI;
        end
        S_MULI: state_r <= S_DIVP;
        S_DIVP: if (rcp_cnt_r == 3'd4) state_r <= S_DIVD;
        S_DIVD: if (dt_r == 20'd0 || div_done) state_r <= S_SUM;
        S_SUM:  state_r <= S_DIVF;
        S_DIVF: if (div_done || !(cfg.safe_distance > cfg.stop_distance)
                    || !(front_r > cfg.stop_distance)) state_r <= S_DIVA;
        S_DIVA: begin
          if (cfg.steer_limit == 15'd0) state_r <= S_SPEED;
          else if (div_done) state_r <= S_INTERP;
        end
        S_INTERP: state_r <= S_SPEED;
        S_SPEED:  state_r <= S_OUT;
        S_OUT: if (!out_valid_r || out_ready) begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (rcp_cnt_r != 3'd4) rcp_acc_r <= rcp_acc_nxt;
    case (state_r)
      S_IDLE: begin
        e_r     <= e_new;
        front_r <= job_data.front_min;
        dt_r    <= job_data.elapsed_us;
      end
      S_MUL1: begin
        edt_r      <= 36'(e_mag) * 36'(dt_r);
        pg_r       <= 32'(cfg.gain_p) * 32'(e_mag);
        pd1_r      <= 33'(cfg.gain_d) * 33'(dmag);
        diff_neg_r <= diff[17];
      end
      S_MUL2: pd2_r <= 49'(pd1_r) * 49'(64000);
      S_MULI: gi_r <= 37'(cfg.gain_i) * 37'(integ_mag);
      S_DIVP: begin
        i_term_r <= integ_r[21] ? -$signed({29'd0, i_rnd[37:14]})
                                : $signed({29'd0, i_rnd[37:14]});
        if (rcp_cnt_r == 3'd4)
          p_term_r <= e_r[16] ? -$signed({24'd0, rcp_acc_r[70:42]})
                              : $signed({24'd0, rcp_acc_r[70:42]});
      end
      S_DIVD: begin
        if (dt_r == 20'd0) d_term_r <= '0;
        else if (div_done) d_term_r <= diff_neg_r ? -$signed(q53) : $signed(q53);
      end
      S_SUM: begin
        steer_r <= steer_clamp;
        mag_r   <= steer_clamp[15] ? 15'(-steer_clamp) : 15'(steer_clamp);
      end
      S_DIVF: begin
        if (!(cfg.safe_distance > cfg.stop_distance))
          df_r <= (front_r >= cfg.stop_distance) ? ONE_Q16 : 17'd0;
        else if (!(front_r > cfg.stop_distance)) df_r <= 17'd0;
        else if (div_done) df_r <= (div_quo > DIV_NUM_W'(ONE_Q16)) ? ONE_Q16 : div_quo[16:0];
      end
      S_DIVA: begin
        if (cfg.steer_limit == 15'd0) af_r <= ONE_Q16;
        else if (div_done)
          ratio_r <= (div_quo > DIV_NUM_W'(ONE_Q16)) ? ONE_Q16 : div_quo[16:0];
      end
      S_INTERP: af_r <= (tab_idx >= 6'd32) ? 17'd0 : tab_a - 17'(drop_prod >> 11);
      S_SPEED: speed_r <= (top > MIN_SPEED) ? MIN_SPEED + 16'(spd_prod >> 16) : MIN_SPEED;
      S_OUT: if (!out_valid_r || out_ready) begin
        out_data_r.speed_cmd <= speed_r;
        out_data_r.steer_cmd <= steer_r;
      end
      default: ;
    endcase
  end

  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r <= 22'sd1048576) && (integ_r >= -22'sd1048576))
    else $error("integral outside its clamp");
  a_speed_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.speed_cmd >= MIN_SPEED) else $error("speed below minimum");
  a_steer_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.steer_cmd <= $signed({1'b0, cfg.steer_limit}))
                 && (out_data_r.steer_cmd >= -$signed({1'b0, cfg.steer_limit})))
    else $error("steering beyond limit");

endmodule

// ===== src/lidar_wall_follow_pid.sv =====
// lidar_wall_follow_pid: top level, config registers and front/back split
// depends on lwf_pkg, lwf_front, lwf_back
// throughput: one sample beat per cycle while the two-deep scan queue has room
// control step per scan: up to three divider passes
// (elapsed time, front ramp, steering ratio), the rest a fixed sequence of states
// a scan's result also waits behind any queued scan and any output stall
// reset (rst_n, synchronous): minima to 65535, integral and previous error to zero
module lidar_wall_follow_pid import lwf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // sample channel
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  // apb-style register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [2:0] cfg_sel;
  logic       job_valid, job_ready;
  job_t       job_data;

  // register write on the access phase of a beat
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wall_distance <= 16'd1300;
      cfg_r.steer_limit   <= 15'd16384;
      cfg_r.gain_p        <= 16'd256;
      cfg_r.gain_i        <= 16'd51;
      cfg_r.gain_d        <= 16'd15;
      cfg_r.stop_distance <= 16'd1400;
      cfg_r.safe_distance <= 16'd2500;
      cfg_r.speed_max     <= 16'd4915;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_WALL_DIST: cfg_r.wall_distance <= pwdata[15:0];
        REG_STEER_LIM: cfg_r.steer_limit   <= pwdata[14:0];
        REG_GAIN_P:    cfg_r.gain_p        <= pwdata[15:0];
        REG_GAIN_I:    cfg_r.gain_i        <= pwdata[15:0];
        REG_GAIN_D:    cfg_r.gain_d        <= pwdata[15:0];
        REG_STOP_DIST: cfg_r.stop_distance <= pwdata[15:0];
        REG_SAFE_DIST: cfg_r.safe_distance <= pwdata[15:0];
        REG_SPEED_MAX: cfg_r.speed_max     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read-back, zero-extended
  always_comb begin
    case (cfg_sel)
      REG_WALL_DIST: prdata = {16'd0, cfg_r.wall_distance};
      REG_STEER_LIM: prdata = {17'd0, cfg_r.steer_limit};
      REG_GAIN_P:    prdata = {16'd0, cfg_r.gain_p};
      REG_GAIN_I:    prdata = {16'd0, cfg_r.gain_i};
      REG_GAIN_D:    prdata = {16'd0, cfg_r.gain_d};
      REG_STOP_DIST: prdata = {16'd0, cfg_r.stop_distance};
      REG_SAFE_DIST: prdata = {16'd0, cfg_r.safe_distance};
      REG_SPEED_MAX: prdata = {16'd0, cfg_r.speed_max};
      default:       prdata = 32'd0;
    endcase
  end

  // front: folds samples into sector minima, queues a finished scan
  lwf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_data  (job_data)
  );

  // back: pid step, speed law, result register
  lwf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_data  (job_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
